// ===== rtl/iwf_pkg.sv =====
// ----------------------------------------------------------------------------
// iwf_pkg
// shared types, constants and the character classifier of the word filter
// ----------------------------------------------------------------------------
package iwf_pkg;

	localparam int unsigned MAX_WORD_LEN_DEF = 64;
	localparam int unsigned QUEUE_DEPTH_DEF  = 4;

	localparam int unsigned CH_W      = 8;
	localparam int unsigned CFG_W     = 7;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned TDATA_W   = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VOWELS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SAME    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CONS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VOWELS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PUNCT   = 3'd5;

	// register reset values
	localparam logic [CFG_W-1:0] RST_MIN_LENGTH = 7'd4;
	localparam logic [CFG_W-1:0] RST_MIN_VOWELS = 7'd1;
	localparam logic [CFG_W-1:0] RST_MAX_SAME   = 7'd2;
	localparam logic [CFG_W-1:0] RST_MAX_CONS   = 7'd5;
	localparam logic [CFG_W-1:0] RST_MAX_VOWELS = 7'd4;
	localparam logic [CFG_W-1:0] RST_MAX_PUNCT  = 7'd1;

	// capital ratio test: caps*PCT_SCALE >= PCT_LIMIT*len means at least 34 percent
	localparam int unsigned PCT_SCALE = 100;
	localparam int unsigned PCT_LIMIT = 34;

	typedef struct packed {
		logic [CFG_W-1:0] min_length;
		logic [CFG_W-1:0] min_vowels;
		logic [CFG_W-1:0] max_run_same;
		logic [CFG_W-1:0] max_run_consonants;
		logic [CFG_W-1:0] max_run_vowels;
		logic [CFG_W-1:0] max_run_punct;
	} cfg_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            is_last;
		logic            is_digit;
		logic            is_punct;
		logic            is_upper;
		logic            is_vow;
	} char_class_t;

	function automatic char_class_t classify(input logic [CH_W-1:0] ch, input logic last);
		char_class_t     r;
		logic [CH_W-1:0] low;
		begin
			r.ch       = ch;
			r.is_last  = last;
			r.is_digit = (ch >= 8'd48) && (ch <= 8'd57);
			r.is_punct = ((ch >= 8'd33) && (ch <= 8'd47)) || ((ch >= 8'd58) && (ch <= 8'd64)) ||
			             ((ch >= 8'd91) && (ch <= 8'd96)) || ((ch >= 8'd123) && (ch <= 8'd126));
			r.is_upper = (ch >= 8'd65) && (ch <= 8'd90);
			low        = r.is_upper ? (ch + 8'd32) : ch;
			r.is_vow   = (low == 8'd97) || (low == 8'd101) || (low == 8'd105) ||
			             (low == 8'd111) || (low == 8'd117);
			return r;
		end
	endfunction

endpackage

// ===== rtl/index_word_filter_unit.sv =====
// ----------------------------------------------------------------------------
// index_word_filter_unit
// decides per word, fed one character a request, whether it is worth indexing
// ----------------------------------------------------------------------------
//
// channel   | dir | handshake            | payload
// ----------+-----+----------------------+-----------------------------------
// s_*       | in  | s_tvalid / s_tready  | s_tdata = ch, s_tlast = is_last
// m_*       | out | m_tvalid / m_tready  | m_tdata[0] = accept
// cfg_*     | in  | cfg_valid / cfg_ready| cfg_index = register, cfg_data
//
// one character request per clock sustained while the queue has room; the
// counter update of the back end handles one queued character per cycle,
// but a last character waits while the snapshot stage is full; the accept bit
// of a word shows on m_tvalid via the queue, then the snapshot register feeding
// the output register; arst_n clears the queue, the word state and both output
// stages; registers return to their documented defaults
// a stalled m_tready holds the result; the queue keeps taking characters
// until it holds QUEUE_DEPTH entries
// ----------------------------------------------------------------------------
module index_word_filter_unit
	import iwf_pkg::*;
#(
	parameter int unsigned MAX_WORD_LEN = MAX_WORD_LEN_DEF,
	parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// character stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [TDATA_W-1:0]   s_tdata,   // [7:0] ch
	input  logic                 s_tlast,   // is_last
	// accept stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_W-1:0]   m_tdata,   // [0] accept, [7:1] zero
	// register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t        cfg_q;
	logic        q_valid;
	logic        q_pop;
	char_class_t q_head;
	logic        accept;

	// registers are always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_length         <= RST_MIN_LENGTH;
			cfg_q.min_vowels         <= RST_MIN_VOWELS;
			cfg_q.max_run_same       <= RST_MAX_SAME;
			cfg_q.max_run_consonants <= RST_MAX_CONS;
			cfg_q.max_run_vowels     <= RST_MAX_VOWELS;
			cfg_q.max_run_punct      <= RST_MAX_PUNCT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_LENGTH: cfg_q.min_length         <= cfg_data;
				REG_MIN_VOWELS: cfg_q.min_vowels         <= cfg_data;
				REG_MAX_SAME:   cfg_q.max_run_same       <= cfg_data;
				REG_MAX_CONS:   cfg_q.max_run_consonants <= cfg_data;
				REG_MAX_VOWELS: cfg_q.max_run_vowels     <= cfg_data;
				REG_MAX_PUNCT:  cfg_q.max_run_punct      <= cfg_data;
				default: ;  // unknown index, write dropped
			endcase
		end
	end

	// front end: classify and queue
	iwf_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_ch   (s_tdata),
		.in_last (s_tlast),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_head  (q_head)
	);

	// back end: counters, runs, decision
	iwf_back #(
		.MAX_WORD_LEN(MAX_WORD_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_head    (q_head),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_accept(accept)
	);

	assign m_tdata = {{(TDATA_W - 1){1'b0}}, accept};

endmodule

// ===== rtl/iwf_front.sv =====
// ----------------------------------------------------------------------------
// iwf_front
// classifies incoming characters and queues them for the counting back end
// ----------------------------------------------------------------------------
module iwf_front
	import iwf_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [CH_W-1:0] in_ch,
	input  logic            in_last,
	output logic            q_valid,
	input  logic            q_pop,
	output char_class_t     q_head
);

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

	char_class_t   mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          push;
	logic          pop;

	assign in_ready = (count_q != NW'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_head   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= classify(in_ch, in_last);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/iwf_back.sv =====
// ----------------------------------------------------------------------------
// iwf_back
// word counters and run tracking, final snapshot stage and accept register
// ----------------------------------------------------------------------------
module iwf_back
	import iwf_pkg::*;
#(
	parameter int unsigned MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	output logic        q_pop,
	input  char_class_t q_head,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_accept
);

	localparam int unsigned CW   = $clog2(MAX_WORD_LEN + 1);
	localparam int unsigned CMPW = (CW > CFG_W) ? CW : CFG_W;
	localparam int unsigned SUMW = CW + 2;
	localparam int unsigned RW   = CW + 8;
	localparam logic [CW-1:0] MAXC = CW'(MAX_WORD_LEN);

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (v >= MAXC) ? MAXC : (v + 1'b1);
	endfunction

	function automatic logic over(input logic [CW-1:0] cnt, input logic [CFG_W-1:0] lim);
		return CMPW'(cnt) > CMPW'(lim);
	endfunction

	// live word state
	logic [CW-1:0]   len_q, digit_q, punct_q, upper_q, vowel_q;
	logic [CW-1:0]   same_q, cons_q, vow_q, prun_q;
	logic [CH_W-1:0] prev_q;
	logic            first_up_q, viol_q;

	logic [CW-1:0]   len_n, digit_n, punct_n, upper_n, vowel_n;
	logic [CW-1:0]   same_n, cons_n, vow_n, prun_n;
	logic [CH_W-1:0] prev_n;
	logic            first_up_n, viol_n;

	// snapshot of a finished word
	logic            s1_valid_q;
	logic [CW-1:0]   len_s1, digit_s1, punct_s1, upper_s1, vowel_s1;
	logic            first_up_s1, viol_s1;

	logic            m_valid_q, accept_q;
	logic            out_free, s1_ready, take;
	logic            accept_d;

	logic [SUMW-1:0] all_sum;
	logic [CW:0]     caps_sum;
	logic [RW-1:0]   caps_scaled, len_scaled;

	assign out_free = !m_valid_q || out_ready;
	assign s1_ready = !s1_valid_q || out_free;
	assign q_pop    = q_valid && (!q_head.is_last || s1_ready);
	assign take     = q_pop;

	always_comb begin
		len_n      = sat_inc(len_q);
		first_up_n = (len_q == '0) ? q_head.is_upper : first_up_q;
		digit_n    = digit_q;
		punct_n    = punct_q;
		upper_n    = upper_q;
		vowel_n    = vowel_q;
		same_n     = same_q;
		cons_n     = cons_q;
		vow_n      = vow_q;
		prun_n     = prun_q;
		prev_n     = prev_q;
		viol_n     = viol_q;
		priority if (q_head.is_digit) begin
			digit_n = sat_inc(digit_q);
			cons_n  = '0;
			vow_n   = '0;
			prun_n  = '0;
			prev_n  = '0;
		end else if (q_head.is_punct) begin
			punct_n = sat_inc(punct_q);
			prun_n  = sat_inc(prun_q);
			viol_n  = viol_n | over(prun_n, cfg.max_run_punct);
			cons_n  = '0;
			vow_n   = '0;
		end else begin
			if (q_head.is_upper) begin
				upper_n = sat_inc(upper_q);
			end
			if (q_head.is_vow) begin
				vowel_n = sat_inc(vowel_q);
			end
			// code zero in prev means no letter seen
			if ((prev_q != '0) && (q_head.ch == prev_q)) begin
				same_n = sat_inc(same_q);
				viol_n = viol_n | over(same_n, cfg.max_run_same);
			end else begin
				same_n = '0;
				prev_n = q_head.ch;
			end
			if (q_head.is_vow) begin
				vow_n  = sat_inc(vow_q);
				viol_n = viol_n | over(vow_n, cfg.max_run_vowels);
				cons_n = '0;
			end else begin
				cons_n = sat_inc(cons_q);
				viol_n = viol_n | over(cons_n, cfg.max_run_consonants);
				vow_n  = '0;
			end
			prun_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			digit_q    <= '0;
			punct_q    <= '0;
			upper_q    <= '0;
			vowel_q    <= '0;
			same_q     <= '0;
			cons_q     <= '0;
			vow_q      <= '0;
			prun_q     <= '0;
			prev_q     <= '0;
			first_up_q <= 1'b0;
			viol_q     <= 1'b0;
		end else if (take) begin
			if (q_head.is_last) begin
				len_q      <= '0;
				digit_q    <= '0;
				punct_q    <= '0;
				upper_q    <= '0;
				vowel_q    <= '0;
				same_q     <= '0;
				cons_q     <= '0;
				vow_q      <= '0;
				prun_q     <= '0;
				prev_q     <= '0;
				first_up_q <= 1'b0;
				viol_q     <= 1'b0;
			end else begin
				len_q      <= len_n;
				digit_q    <= digit_n;
				punct_q    <= punct_n;
				upper_q    <= upper_n;
				vowel_q    <= vowel_n;
				same_q     <= same_n;
				cons_q     <= cons_n;
				vow_q      <= vow_n;
				prun_q     <= prun_n;
				prev_q     <= prev_n;
				first_up_q <= first_up_n;
				viol_q     <= viol_n;
			end
		end
	end

	// snapshot payload
	always_ff @(posedge clk) begin
		if (take && q_head.is_last) begin
			len_s1      <= len_n;
			digit_s1    <= digit_n;
			punct_s1    <= punct_n;
			upper_s1    <= upper_n;
			vowel_s1    <= vowel_n;
			first_up_s1 <= first_up_n;
			viol_s1     <= viol_n;
		end
	end

	// decision on the snapshot
	assign all_sum     = SUMW'(upper_s1) + SUMW'(digit_s1) + SUMW'(punct_s1);
	assign caps_sum    = (CW + 1)'(upper_s1) + (CW + 1)'(digit_s1);
	assign caps_scaled = RW'(caps_sum) * RW'(PCT_SCALE);
	assign len_scaled  = RW'(len_s1) * RW'(PCT_LIMIT);

	always_comb begin
		priority if (first_up_s1 && (all_sum == SUMW'(len_s1))) begin
			accept_d = 1'b1;
		end else if (first_up_s1 && (caps_scaled >= len_scaled)) begin
			accept_d = 1'b0;
		end else if (!first_up_s1 && (upper_s1 != '0)) begin
			accept_d = 1'b0;
		end else if (CMPW'(len_s1) < CMPW'(cfg.min_length)) begin
			accept_d = 1'b0;
		end else if (CMPW'(vowel_s1) < CMPW'(cfg.min_vowels)) begin
			accept_d = 1'b0;
		end else begin
			accept_d = !viol_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (s1_ready) begin
				s1_valid_q <= take && q_head.is_last;
			end
			if (out_free) begin
				m_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_valid_q) begin
			accept_q <= accept_d;
		end
	end

	assign out_valid  = m_valid_q;
	assign out_accept = accept_q;

endmodule

// ===== rtl/iwf_checker.sv =====
// ----------------------------------------------------------------------------
// iwf_checker
// port-level checks of the word filter, bound to the top level
// ----------------------------------------------------------------------------
module iwf_checker
	import iwf_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [TDATA_W-1:0]   m_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");

	// only the accept bit carries data
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[TDATA_W-1:1] == '0))
		else $error("result padding not zero");

	// reset empties the output stage
	a_rst_out: assert property (@(posedge clk)
		!arst_n |-> (m_tvalid !== 1'b1))
		else $error("result valid during reset");

	// a result does not rise straight out of reset
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(!arst_n, 1) && !$past(!arst_n, 2))
		else $error("result too soon after reset");

endmodule

bind index_word_filter_unit iwf_checker u_iwf_checker (.*);

// ===== sim/iwf_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// iwf_scoreboard_pkg
// word decision predictor and the store of accept bits it expects
// ----------------------------------------------------------------------------
package iwf_scoreboard_pkg;

	import iwf_pkg::*;

	localparam logic [CFG_W-1:0] WORD_CAP = CFG_W'(MAX_WORD_LEN_DEF);

	class word_verdict_board;
		cfg_t             regs;
		logic [CFG_W-1:0] len_cnt, digit_cnt, punct_cnt, upper_cnt, vowel_cnt;
		logic [CFG_W-1:0] same_run, cons_run, vowel_run, punct_run;
		logic [CH_W-1:0]  prev_ltr;
		logic             first_upper;
		logic             run_bad;
		logic             verdict_q[$];
		int               errors;
		int               words_done;

		function new();
			regs.min_length         = 7'd4;
			regs.min_vowels         = 7'd1;
			regs.max_run_same       = 7'd2;
			regs.max_run_consonants = 7'd5;
			regs.max_run_vowels     = 7'd4;
			regs.max_run_punct      = 7'd1;
			errors     = 0;
			words_done = 0;
			clear_word();
		endfunction

		function void clear_word();
			len_cnt     = '0;
			digit_cnt   = '0;
			punct_cnt   = '0;
			upper_cnt   = '0;
			vowel_cnt   = '0;
			same_run    = '0;
			cons_run    = '0;
			vowel_run   = '0;
			punct_run   = '0;
			prev_ltr    = '0;
			first_upper = 1'b0;
			run_bad     = 1'b0;
		endfunction

		function logic [CFG_W-1:0] bump(input logic [CFG_W-1:0] v);
			return (v >= WORD_CAP) ? WORD_CAP : v + 7'd1;
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction

		function void note_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
			unique case (idx)
				REG_MIN_LENGTH: regs.min_length         = val;
				REG_MIN_VOWELS: regs.min_vowels         = val;
				REG_MAX_SAME:   regs.max_run_same       = val;
				REG_MAX_CONS:   regs.max_run_consonants = val;
				REG_MAX_VOWELS: regs.max_run_vowels     = val;
				REG_MAX_PUNCT:  regs.max_run_punct      = val;
				default: ;
			endcase
		endfunction

		// one character request; a word end pushes the expected accept bit
		function void note_char(input logic [CH_W-1:0] ch, input logic last);
			logic            dig, pun, up, vow, acc;
			logic [CH_W-1:0] low;
			int              len, caps;
			dig = ch inside {[8'd48:8'd57]};
			pun = ch inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]};
			up  = ch inside {[8'd65:8'd90]};
			low = up ? ch + 8'd32 : ch;
			vow = low inside {8'd97, 8'd101, 8'd105, 8'd111, 8'd117};

			if (len_cnt == 0)
				first_upper = up;
			len_cnt = bump(len_cnt);

			if (dig) begin
				digit_cnt = bump(digit_cnt);
				cons_run  = '0;
				vowel_run = '0;
				punct_run = '0;
				prev_ltr  = '0;
			end else if (pun) begin
				punct_cnt = bump(punct_cnt);
				punct_run = bump(punct_run);
				if (punct_run > regs.max_run_punct)
					run_bad = 1'b1;
				cons_run  = '0;
				vowel_run = '0;
			end else begin
				if (up)
					upper_cnt = bump(upper_cnt);
				if (vow)
					vowel_cnt = bump(vowel_cnt);
				// zero in prev_ltr means no letter seen, so code zero never repeats
				if (prev_ltr != 0 && ch == prev_ltr) begin
					same_run = bump(same_run);
					if (same_run > regs.max_run_same)
						run_bad = 1'b1;
				end else begin
					same_run = '0;
					prev_ltr = ch;
				end
				if (vow) begin
					vowel_run = bump(vowel_run);
					if (vowel_run > regs.max_run_vowels)
						run_bad = 1'b1;
					cons_run = '0;
				end else begin
					cons_run = bump(cons_run);
					if (cons_run > regs.max_run_consonants)
						run_bad = 1'b1;
					vowel_run = '0;
				end
				punct_run = '0;
			end

			if (!last)
				return;

			len  = int'(len_cnt);
			caps = int'(upper_cnt) + int'(digit_cnt);
			if (first_upper && caps + int'(punct_cnt) == len)
				acc = 1'b1;
			else if (first_upper && caps * 100 >= 34 * len)
				acc = 1'b0;
			else if (!first_upper && upper_cnt != 0)
				acc = 1'b0;
			else if (len_cnt < regs.min_length)
				acc = 1'b0;
			else if (vowel_cnt < regs.min_vowels)
				acc = 1'b0;
			else
				acc = !run_bad;
			verdict_q.push_back(acc);
			clear_word();
		endfunction

		task report(input string what);
			errors++;
			$display("[%0t] word %0d: %s", $time, words_done, what);
		endtask

		task check_result(input logic [TDATA_W-1:0] data);
			logic exp;
			if (verdict_q.size() == 0) begin
				report($sformatf("accept 0x%02h with no word pending", data));
				return;
			end
			exp = verdict_q.pop_front();
			if (data[0] !== exp)
				report($sformatf("accept got %b want %b", data[0], exp));
			if (data[TDATA_W-1:1] !== '0)
				report($sformatf("padding bits not zero, tdata 0x%02h", data));
			words_done++;
		endtask
	endclass

endpackage

// ===== sim/index_word_filter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// index_word_filter_unit_tb
// feeds words one character per request, with random bursts, gaps and output
// stalls, under several register settings, and checks every accept bit
// against a predictor of the word decision
// ----------------------------------------------------------------------------
module index_word_filter_unit_tb
	import iwf_pkg::*, iwf_scoreboard_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	// indexes past the register file, writes to them must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int CHARS_PER_PHASE = 150;
	localparam int NUM_PHASES      = 8;
	localparam int LONG_HOLD       = 300;
	localparam int WATCHDOG_LIMIT  = 3000;

	typedef enum {CK_VOWEL, CK_CONS, CK_UPPER, CK_DIGIT, CK_PUNCT, CK_ANY, CK_REPEAT} char_kind_t;
	typedef enum {WS_LOWER, WS_CAPITAL, WS_ACRONYM, WS_MIXED, WS_NOISE} word_style_t;
	typedef enum {CFG_ZERO, CFG_MID, CFG_TOP, CFG_RANDOM} cfg_mode_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata   = '0;   // [7:0] ch
	logic                 s_tlast   = 1'b0; // is_last
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;          // [0] accept, [7:1] zero
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	word_verdict_board board = new();

	// sender and receiver knobs, set per phase by the main sequence
	bit    gaps_on       = 1'b1;
	int    stall_pct     = 0;
	bit    pattern_mode  = 1'b0;
	bit    long_hold_go  = 1'b0;
	int    hold_left     = 0;
	int    rx_cyc        = 0;
	int    burst_left    = 0;
	int    chars_sent    = 0;
	int    idle_cycles   = 0;
	string vowel_set     = "aeiou";
	string cons_set      = "bcdfghjklmnpqrstvwxyz";

	index_word_filter_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// monitor: every handshake is seen here at the rising edge, before the
	// block's own updates land, so the sampled values are the pre-edge ones
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				board.note_char(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				board.check_result(m_tdata);
			if (cfg_valid && cfg_ready)
				board.note_config(cfg_index, cfg_data);
		end
	end

	// watchdog on cycles with no request of any kind taken
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request taken for %0d cycles", WATCHDOG_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// receiver: random or periodic stalls, plus a long hold when asked for
	always @(negedge clk) begin
		rx_cyc++;
		if (long_hold_go) begin
			long_hold_go = 1'b0;
			hold_left    = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (pattern_mode) begin
			m_tready <= (rx_cyc % 5 != 0) && (rx_cyc % 11 != 3);
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// one character request; bursts of random length, with random gaps between when gaps_on is set
	task send_char(input logic [CH_W-1:0] ch, input logic last);
		int gap;
		if (burst_left == 0) begin
			if (gaps_on) begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		chars_sent++;
	endtask

	task send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	// one random word in the given style; a few are past the length cap
	task send_word(input word_style_t style);
		int              n, r;
		char_kind_t      kind;
		logic [CH_W-1:0] c, prev;
		n    = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 10);
		prev = 8'd97;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			unique case (style)
				WS_LOWER, WS_CAPITAL: begin
					kind = (r < 35) ? CK_VOWEL : (r < 72) ? CK_CONS : (r < 85) ? CK_REPEAT :
					       (r < 90) ? CK_DIGIT : (r < 95) ? CK_PUNCT : (r < 98) ? CK_UPPER : CK_ANY;
				end
				WS_ACRONYM: begin
					kind = (r < 70) ? CK_UPPER : (r < 82) ? CK_DIGIT : (r < 94) ? CK_PUNCT :
					       (r < 97) ? CK_VOWEL : CK_CONS;
				end
				WS_MIXED: kind = char_kind_t'(r % 7);
				default:  kind = CK_ANY;
			endcase
			if (i == 0 && (style == WS_CAPITAL || style == WS_ACRONYM))
				kind = CK_UPPER;
			unique case (kind)
				CK_VOWEL: begin
					c = vowel_set[$urandom_range(0, 4)];
					if (style == WS_MIXED && $urandom_range(0, 3) == 0)
						c = c - 8'd32;
				end
				CK_CONS:  c = cons_set[$urandom_range(0, 20)];
				CK_UPPER: c = CH_W'($urandom_range(65, 90));
				CK_DIGIT: c = CH_W'($urandom_range(48, 57));
				CK_PUNCT: begin
					r = $urandom_range(0, 31);
					if (r < 15)
						c = CH_W'(33 + r);
					else if (r < 22)
						c = CH_W'(58 + r - 15);
					else if (r < 28)
						c = CH_W'(91 + r - 22);
					else
						c = CH_W'(123 + r - 28);
				end
				CK_REPEAT: c = prev;
				default:   c = CH_W'($urandom_range(0, 255));
			endcase
			send_char(c, i == n - 1);
			prev = c;
		end
	endtask

	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// full register set, then the two spare indexes that must be ignored
	task program_regs(input cfg_mode_t mode);
		logic [CFG_W-1:0] v;
		int               r;
		for (int i = REG_MIN_LENGTH; i <= REG_MAX_PUNCT; i++) begin
			unique case (mode)
				CFG_ZERO: v = 7'd0;
				CFG_MID:  v = 7'd64;
				CFG_TOP:  v = 7'd127;
				default: begin
					r = $urandom_range(0, 9);
					v = (r == 0) ? 7'd0 : (r == 1) ? 7'd64 : (r == 2) ? 7'd127 :
					    CFG_W'($urandom_range(0, 8));
				end
			endcase
			write_reg(CFG_IDX_W'(i), v);
		end
		write_reg(REG_SPARE_LO, CFG_W'($urandom_range(0, 127)));
		write_reg(REG_SPARE_HI, CFG_W'($urandom_range(0, 127)));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// the sender pauses until every pending accept bit has come back
	task drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		// latency margin so nothing is in flight before a register write
		repeat (10) @(posedge clk);
	endtask

	initial begin
		int          phase_start, r;
		word_style_t style;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			unique case (ph)
				1:       program_regs(CFG_RANDOM);
				2:       program_regs(CFG_ZERO);
				3:       program_regs(CFG_MID);
				4:       program_regs(CFG_TOP);
				default: if (ph != 0) program_regs(CFG_RANDOM);
			endcase

			gaps_on      = (ph != 3) && (ph != 5);
			stall_pct    = (ph == 3) ? 0 : $urandom_range(5, 60);
			pattern_mode = (ph == 6);
			burst_left   = 0;

			// long output hold while the sender keeps offering: the queue fills
			// and the block has to drop s_tready
			if (ph == 5)
				long_hold_go = 1'b1;

			phase_start = chars_sent;

			if (ph == 0) begin
				// directed words under reset values
				send_text("A");      // single capital, acronym
				send_text("Hello");  // capital start, repeat within limit
				send_text("eBay");   // interior capital
				send_text("9!?");    // digit then punctuation run over limit
				send_text("x");      // too short
				send_text("ABC1."); // acronym with digit and punctuation
				// code zero is never a repeat, code 255 is a plain consonant
				send_char(8'd0, 1'b0);
				send_char(8'd0, 1'b0);
				send_char(8'd255, 1'b0);
				send_char(8'd255, 1'b1);
			end

			while (chars_sent < phase_start + CHARS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				style = (r < 40) ? WS_LOWER : (r < 60) ? WS_CAPITAL : (r < 75) ? WS_ACRONYM :
				        (r < 90) ? WS_MIXED : WS_NOISE;
				send_word(style);
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/iwf_pkg.sv
rtl/iwf_front.sv
rtl/iwf_back.sv
rtl/index_word_filter_unit.sv
rtl/iwf_checker.sv
sim/iwf_scoreboard_pkg.sv
sim/index_word_filter_unit_tb.sv
